// ===== hdl/gsp_pkg.sv =====
`default_nettype none

package gsp_pkg;

    // Geometry of the state: three rows of four 32-bit words.
    localparam int GSP_WORD_W      = 32;
    localparam int GSP_WORD_COUNT  = 12;
    localparam int GSP_COL_COUNT   = 4;
    localparam int GSP_ROUND_COUNT = 24;

    localparam logic [GSP_WORD_W-1:0] GSP_ROUND_CONST = 32'h7937_9E00;

    // Position of a round inside its group of four.
    localparam logic [1:0] GSP_PHASE_SMALL_SWAP = 2'd0;
    localparam logic [1:0] GSP_PHASE_BIG_SWAP   = 2'd2;

    typedef logic [GSP_WORD_W-1:0] word_t;
    typedef word_t [GSP_WORD_COUNT-1:0] state_t;

    // One column of the scramble: a, b, d are rows 0, 1 and 2.
    typedef struct packed {
        word_t a;
        word_t b;
        word_t d;
    } column_t;

    function automatic column_t mix_column(input column_t c);
        column_t r;
        word_t   x;
        word_t   y;
        word_t   z;
        x   = {c.a[7:0], c.a[31:8]};
        y   = {c.b[22:0], c.b[31:23]};
        z   = c.d;
        r.a = z ^ y ^ ((x & y) << 3);
        r.b = y ^ x ^ ((x | z) << 1);
        r.d = x ^ (z << 1) ^ ((y & z) << 2);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/gsp_round_cell.sv =====
`default_nettype none

module gsp_round_cell #(
    parameter int ROUND_INDEX = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            valid_in,
    input  wire gsp_pkg::state_t state_in,
    output logic                 valid_out,
    output gsp_pkg::state_t      state_out
);
    import gsp_pkg::*;

    localparam logic [1:0] PHASE    = 2'(ROUND_INDEX % 4);
    localparam word_t      ROUND_RC = GSP_ROUND_CONST ^ GSP_WORD_W'(ROUND_INDEX);

    state_t mixed;
    state_t state_next;
    state_t state_reg;
    logic   valid_reg;

    // Column scramble on all four columns in parallel.
    always_comb
    begin
        column_t c;
        mixed = state_in;
        for (int col = 0; col < GSP_COL_COUNT; col++)
        begin
            c = mix_column('{a: state_in[col],
                             b: state_in[col + GSP_COL_COUNT],
                             d: state_in[col + 2 * GSP_COL_COUNT]});
            mixed[col]                     = c.a;
            mixed[col + GSP_COL_COUNT]     = c.b;
            mixed[col + 2 * GSP_COL_COUNT] = c.d;
        end
    end

    // Word swaps in row 0 and the round constant, chosen by the round phase.
    always_comb
    begin
        state_next = mixed;
        case (PHASE)
            GSP_PHASE_SMALL_SWAP:
            begin
                state_next[0] = mixed[1] ^ ROUND_RC;
                state_next[1] = mixed[0];
                state_next[2] = mixed[3];
                state_next[3] = mixed[2];
            end
            GSP_PHASE_BIG_SWAP:
            begin
                state_next[0] = mixed[2];
                state_next[1] = mixed[3];
                state_next[2] = mixed[0];
                state_next[3] = mixed[1];
            end
            default:
            begin
                state_next = mixed;
            end
        endcase
    end

    // The valid flag is control state; the words are payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;

endmodule

`default_nettype wire

// ===== hdl/gimli_style_permutation_384_core.sv =====
`default_nettype none

// Channel   Ports                          Handshake
// -------   -----------------------------  --------------------------------------
// command   start, busy, in_word_0..11     taken at an edge with start=1, busy=0
// result    done, out_word_0..11           valid for the one cycle that done is 1
//
// A transaction passes through the round cells in order, each registering its
// state; the result comes from the last cell. The round cells form a pipeline and a
// new transaction may be taken in every cycle; busy is never raised.
// Reset clears only the valid flags of the cells. The receiver cannot stall,
// so results leave in the order their commands were taken.

module gimli_style_permutation_384_core #(
    parameter int ROUND_COUNT = gsp_pkg::GSP_ROUND_COUNT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire gsp_pkg::word_t      in_word_0,
    input  wire gsp_pkg::word_t      in_word_1,
    input  wire gsp_pkg::word_t      in_word_2,
    input  wire gsp_pkg::word_t      in_word_3,
    input  wire gsp_pkg::word_t      in_word_4,
    input  wire gsp_pkg::word_t      in_word_5,
    input  wire gsp_pkg::word_t      in_word_6,
    input  wire gsp_pkg::word_t      in_word_7,
    input  wire gsp_pkg::word_t      in_word_8,
    input  wire gsp_pkg::word_t      in_word_9,
    input  wire gsp_pkg::word_t      in_word_10,
    input  wire gsp_pkg::word_t      in_word_11,
    output logic                     done,
    output gsp_pkg::word_t           out_word_0,
    output gsp_pkg::word_t           out_word_1,
    output gsp_pkg::word_t           out_word_2,
    output gsp_pkg::word_t           out_word_3,
    output gsp_pkg::word_t           out_word_4,
    output gsp_pkg::word_t           out_word_5,
    output gsp_pkg::word_t           out_word_6,
    output gsp_pkg::word_t           out_word_7,
    output gsp_pkg::word_t           out_word_8,
    output gsp_pkg::word_t           out_word_9,
    output gsp_pkg::word_t           out_word_10,
    output gsp_pkg::word_t           out_word_11
);
    import gsp_pkg::*;

    logic   stage_valid [ROUND_COUNT+1];
    state_t stage_state [ROUND_COUNT+1];

    // The pipeline never refuses a command.
    assign busy = 1'b0;

    // Entry of the chain.
    assign stage_valid[0] = start & ~busy;
    assign stage_state[0] = {in_word_11, in_word_10, in_word_9, in_word_8,
                             in_word_7,  in_word_6,  in_word_5, in_word_4,
                             in_word_3,  in_word_2,  in_word_1, in_word_0};

    // One round cell per round, each handing its state to the next.
    for (genvar r = 0; r < ROUND_COUNT; r++)
    begin : g_round
        gsp_round_cell #(
            .ROUND_INDEX (r)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (stage_valid[r]),
            .state_in  (stage_state[r]),
            .valid_out (stage_valid[r+1]),
            .state_out (stage_state[r+1])
        );
    end

    // Exit of the chain.
    assign done        = stage_valid[ROUND_COUNT];
    assign out_word_0  = stage_state[ROUND_COUNT][0];
    assign out_word_1  = stage_state[ROUND_COUNT][1];
    assign out_word_2  = stage_state[ROUND_COUNT][2];
    assign out_word_3  = stage_state[ROUND_COUNT][3];
    assign out_word_4  = stage_state[ROUND_COUNT][4];
    assign out_word_5  = stage_state[ROUND_COUNT][5];
    assign out_word_6  = stage_state[ROUND_COUNT][6];
    assign out_word_7  = stage_state[ROUND_COUNT][7];
    assign out_word_8  = stage_state[ROUND_COUNT][8];
    assign out_word_9  = stage_state[ROUND_COUNT][9];
    assign out_word_10 = stage_state[ROUND_COUNT][10];
    assign out_word_11 = stage_state[ROUND_COUNT][11];

endmodule

`default_nettype wire
